// ===== rtl/vna_pkg.sv =====
// vna_pkg: shared types and constants of the vertex normal averager
// no dependencies; used by vertex_normal_averager under rtl and by the testbench

package vna_pkg;

  localparam int unsigned MaxVertices = 4096;
  localparam int unsigned FracBits    = 14;
  localparam int unsigned IdxW        = 12;
  localparam int unsigned FaceW       = 16;
  localparam int unsigned UnitW       = 16;
  localparam int unsigned SumW        = 32;
  localparam int unsigned StoreDepth  = (MaxVertices < 4096) ? MaxVertices : 4096;
  localparam int unsigned AddrW       = $clog2(StoreDepth);
  localparam int unsigned QuotW       = FracBits + 1;
  localparam int unsigned NumW        = SumW + FracBits + 2;
  localparam int unsigned DenW        = SumW + 1;

  localparam logic REQ_ACCUM = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  typedef struct packed {
    logic                    req_type;
    logic [IdxW-1:0]         vertex_a;
    logic [IdxW-1:0]         vertex_b;
    logic [IdxW-1:0]         vertex_c;
    logic signed [FaceW-1:0] face_x;
    logic signed [FaceW-1:0] face_y;
    logic signed [FaceW-1:0] face_z;
  } in_word_t;

  typedef struct packed {
    logic signed [UnitW-1:0] unit_x;
    logic signed [UnitW-1:0] unit_y;
    logic signed [UnitW-1:0] unit_z;
    logic                    zero_sum;
    logic                    clipped;
  } out_word_t;

  typedef struct packed {
    logic                   clip;
    logic signed [SumW-1:0] z;
    logic signed [SumW-1:0] y;
    logic signed [SumW-1:0] x;
  } mem_word_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_RD_RD,
    ST_RD_CAP,
    ST_SQ,
    ST_ROOT,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

// ===== rtl/vna_ram.sv =====
// vna_ram: generic single-clock ram, one write port, one registered read port
// no dependencies

module vna_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/vertex_normal_averager.sv =====
// vertex_normal_averager: top level, sequencer and datapath around the vertex store
// depends on vna_pkg and vna_ram

// Keeps one 97-bit entry per vertex (three saturating 32-bit sums and a clip
// mark) in a single ram with a registered read port. After reset the block
// runs a clearing pass over the store, one entry a cycle, and holds
// in_stall_o high until it ends. Items are taken one at a time. An accumulate
// word does a read-modify-write per vertex (ACC_RD, then ACC_WR); the three
// updates are strictly ordered, so a vertex repeated in a triangle adds the
// normal once per occurrence. A read word captures the entry and clears it
// (RD_RD, RD_CAP), forms the squared length on one 32x32 multiplier (SQ),
// takes a bit-serial integer square root (ROOT, one result bit a cycle), then
// divides each component on a shared restoring divider (DIV). A zero sum
// skips the root and the divider and reports zero_sum. Results sit in an
// output register, so the next word is accepted while a finished result still
// waits under out_stall_i.

module vertex_normal_averager (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  vna_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output vna_pkg::out_word_t out_word_o
);

  localparam int unsigned MemW = $bits(vna_pkg::mem_word_t);
  localparam int unsigned DcntW = $clog2(vna_pkg::QuotW + 1);

  vna_pkg::state_e state_q, state_d;

  // control counters
  logic [vna_pkg::AddrW-1:0] clr_addr_q;
  logic [1:0]                k_q;       // vertex or component slot
  logic [1:0]                sq_cnt_q;
  logic [4:0]                root_cnt_q;
  logic [DcntW-1:0]          dcnt_q;
  logic                      out_valid_q;

  // payload registers
  vna_pkg::in_word_t         item_q;
  vna_pkg::mem_word_t        cap_q;
  logic [63:0]               prod_q;
  logic [63:0]               ssum_q;
  logic [34:0]               rem_q;
  logic [31:0]               root_q;
  logic [vna_pkg::DenW:0]    drem_q;
  logic [vna_pkg::QuotW-1:0] dlo_q;
  logic [vna_pkg::QuotW-1:0] quot_q;
  logic [vna_pkg::QuotW-1:0] q_x_q, q_y_q, q_z_q;
  vna_pkg::out_word_t        out_q;

  // ram port
  logic                      ram_we;
  logic [vna_pkg::AddrW-1:0] ram_waddr, ram_raddr;
  vna_pkg::mem_word_t        ram_wdata, ram_rdata;

  vna_ram #(
    .Width (MemW),
    .Depth (vna_pkg::StoreDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // vertex of the current slot
  logic [vna_pkg::AddrW-1:0] cur_vtx;
  always_comb begin
    case (k_q)
      2'd0:    cur_vtx = item_q.vertex_a[vna_pkg::AddrW-1:0];
      2'd1:    cur_vtx = item_q.vertex_b[vna_pkg::AddrW-1:0];
      default: cur_vtx = item_q.vertex_c[vna_pkg::AddrW-1:0];
    endcase
  end

  // saturating update of one entry
  logic [32:0] nx, ny, nz;
  logic        ovx, ovy, ovz;
  vna_pkg::mem_word_t acc_word;
  always_comb begin
    nx = {ram_rdata.x[31], ram_rdata.x} + {{17{item_q.face_x[15]}}, item_q.face_x};
    ny = {ram_rdata.y[31], ram_rdata.y} + {{17{item_q.face_y[15]}}, item_q.face_y};
    nz = {ram_rdata.z[31], ram_rdata.z} + {{17{item_q.face_z[15]}}, item_q.face_z};
    ovx = nx[32] ^ nx[31];
    ovy = ny[32] ^ ny[31];
    ovz = nz[32] ^ nz[31];
    acc_word.x = ovx ? (nx[32] ? 32'h8000_0000 : 32'h7fff_ffff) : nx[31:0];
    acc_word.y = ovy ? (ny[32] ? 32'h8000_0000 : 32'h7fff_ffff) : ny[31:0];
    acc_word.z = ovz ? (nz[32] ? 32'h8000_0000 : 32'h7fff_ffff) : nz[31:0];
    acc_word.clip = ram_rdata.clip | ovx | ovy | ovz;
  end

  // magnitude and sign of the captured component in slot k
  logic [31:0] comp_s;
  logic [31:0] comp_mag;
  always_comb begin
    case (k_q)
      2'd0:    comp_s = cap_q.x;
      2'd1:    comp_s = cap_q.y;
      default: comp_s = cap_q.z;
    endcase
    comp_mag = comp_s[31] ? (32'd0 - comp_s) : comp_s;
  end

  // squaring: sq_cnt selects the component through k
  logic [63:0] sq_prod;
  assign sq_prod = {32'd0, comp_mag} * {32'd0, comp_mag};

  // one root bit per cycle
  logic [1:0]  root_pair;
  logic [34:0] rem_sh, root_trial;
  logic        root_ge;
  always_comb begin
    root_pair  = ssum_q[{root_cnt_q, 1'b0} +: 2];
    rem_sh     = {rem_q[32:0], root_pair};
    root_trial = {1'b0, root_q, 2'b01};
    root_ge    = (rem_sh >= root_trial);
  end

  // divider: numerator (|s| << (f+1)) + len, denominator 2*len
  logic [vna_pkg::NumW-1:0] div_num;
  logic [vna_pkg::DenW-1:0] div_den;
  logic [vna_pkg::DenW:0]   drem_sh;
  logic                     div_ge;
  logic [vna_pkg::QuotW-1:0] quot_nx, quot_lim;
  always_comb begin
    div_num = ({{(vna_pkg::NumW-32){1'b0}}, comp_mag} << (vna_pkg::FracBits + 1))
            + {{(vna_pkg::NumW-32){1'b0}}, root_q};
    div_den = {root_q, 1'b0};
    drem_sh = {drem_q[vna_pkg::DenW-1:0], dlo_q[vna_pkg::QuotW-1]};
    div_ge  = (drem_sh >= {1'b0, div_den});
    quot_nx = {quot_q[vna_pkg::QuotW-2:0], div_ge};
    quot_lim = (quot_nx > vna_pkg::QuotW'(1 << vna_pkg::FracBits))
             ? vna_pkg::QuotW'(1 << vna_pkg::FracBits) : quot_nx;
  end

  // signed unit component
  function automatic logic [vna_pkg::UnitW-1:0] apply_sign(
    input logic [vna_pkg::QuotW-1:0] q,
    input logic                      neg
  );
    logic [vna_pkg::UnitW-1:0] m;
    m = {{(vna_pkg::UnitW-vna_pkg::QuotW){1'b0}}, q};
    return neg ? (vna_pkg::UnitW'(0) - m) : m;
  endfunction

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      vna_pkg::ST_CLEAR: begin
        if (&clr_addr_q) state_d = vna_pkg::ST_IDLE;
      end
      vna_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_word_i.req_type == vna_pkg::REQ_READ) ?
                    vna_pkg::ST_RD_RD : vna_pkg::ST_ACC_RD;
        end
      end
      vna_pkg::ST_ACC_RD: state_d = vna_pkg::ST_ACC_WR;
      vna_pkg::ST_ACC_WR: begin
        state_d = (k_q == 2'd2) ? vna_pkg::ST_IDLE : vna_pkg::ST_ACC_RD;
      end
      vna_pkg::ST_RD_RD:  state_d = vna_pkg::ST_RD_CAP;
      vna_pkg::ST_RD_CAP: state_d = vna_pkg::ST_SQ;
      vna_pkg::ST_SQ: begin
        if (sq_cnt_q == 2'd3) state_d = vna_pkg::ST_ROOT;
      end
      vna_pkg::ST_ROOT: begin
        if (ssum_q == 64'd0)        state_d = vna_pkg::ST_DONE;
        else if (root_cnt_q == 5'd0) state_d = vna_pkg::ST_DIV;
      end
      vna_pkg::ST_DIV: begin
        if (dcnt_q == DcntW'(vna_pkg::QuotW) && k_q == 2'd2) state_d = vna_pkg::ST_DONE;
      end
      vna_pkg::ST_DONE: begin
        if (out_free) state_d = vna_pkg::ST_IDLE;
      end
      default: state_d = vna_pkg::ST_IDLE;
    endcase
  end

  // ram control and input stall
  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = cur_vtx;
    ram_wdata  = acc_word;
    ram_raddr  = cur_vtx;
    in_stall_o = (state_q != vna_pkg::ST_IDLE);
    case (state_q)
      vna_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_q;
        ram_wdata = '0;
      end
      vna_pkg::ST_ACC_WR: begin
        ram_we = 1'b1;
      end
      vna_pkg::ST_RD_CAP: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vna_pkg::ST_CLEAR;
      clr_addr_q  <= '0;
      k_q         <= '0;
      sq_cnt_q    <= '0;
      root_cnt_q  <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // a new result loads, or a waiting one stays until taken
      out_valid_q <= (state_q == vna_pkg::ST_DONE && out_free) ||
                     (out_valid_q && out_stall_i);
      case (state_q)
        vna_pkg::ST_CLEAR: clr_addr_q <= clr_addr_q + 1'b1;
        vna_pkg::ST_IDLE: begin
          k_q <= '0;
        end
        vna_pkg::ST_ACC_WR: k_q <= k_q + 1'b1;
        vna_pkg::ST_RD_CAP: begin
          sq_cnt_q <= '0;
          k_q      <= '0;
        end
        vna_pkg::ST_SQ: begin
          sq_cnt_q <= sq_cnt_q + 1'b1;
          k_q      <= (k_q == 2'd2) ? 2'd2 : k_q + 1'b1;
          root_cnt_q <= 5'd31;
        end
        vna_pkg::ST_ROOT: begin
          root_cnt_q <= root_cnt_q - 1'b1;
          k_q        <= '0;
          dcnt_q     <= '0;
        end
        vna_pkg::ST_DIV: begin
          if (dcnt_q == DcntW'(vna_pkg::QuotW)) begin
            dcnt_q <= '0;
            k_q    <= k_q + 1'b1;
          end else begin
            dcnt_q <= dcnt_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      vna_pkg::ST_IDLE: begin
        if (in_valid_i) item_q <= in_word_i;
      end
      vna_pkg::ST_RD_CAP: begin
        cap_q  <= ram_rdata;
        ssum_q <= '0;
      end
      vna_pkg::ST_SQ: begin
        if (sq_cnt_q != 2'd3) prod_q <= sq_prod;
        if (sq_cnt_q != 2'd0) ssum_q <= ssum_q + prod_q;
        rem_q  <= '0;
        root_q <= '0;
      end
      vna_pkg::ST_ROOT: begin
        if (root_ge) begin
          rem_q  <= rem_sh - root_trial;
          root_q <= {root_q[30:0], 1'b1};
        end else begin
          rem_q  <= rem_sh;
          root_q <= {root_q[30:0], 1'b0};
        end
      end
      vna_pkg::ST_DIV: begin
        if (dcnt_q == '0) begin
          drem_q <= {1'b0, div_num[vna_pkg::NumW-1:vna_pkg::QuotW]};
          dlo_q  <= div_num[vna_pkg::QuotW-1:0];
          quot_q <= '0;
        end else begin
          drem_q <= div_ge ? (drem_sh - {1'b0, div_den}) : drem_sh;
          dlo_q  <= {dlo_q[vna_pkg::QuotW-2:0], 1'b0};
          quot_q <= quot_nx;
          if (dcnt_q == DcntW'(vna_pkg::QuotW)) begin
            case (k_q)
              2'd0:    q_x_q <= quot_lim;
              2'd1:    q_y_q <= quot_lim;
              default: q_z_q <= quot_lim;
            endcase
          end
        end
      end
      vna_pkg::ST_DONE: begin
        if (out_free) begin
          out_q.clipped  <= cap_q.clip;
          out_q.zero_sum <= (ssum_q == 64'd0);
          if (ssum_q == 64'd0) begin
            out_q.unit_x <= '0;
            out_q.unit_y <= '0;
            out_q.unit_z <= '0;
          end else begin
            out_q.unit_x <= apply_sign(q_x_q, cap_q.x[31]);
            out_q.unit_y <= apply_sign(q_y_q, cap_q.y[31]);
            out_q.unit_z <= apply_sign(q_z_q, cap_q.z[31]);
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ===== dv/tb_top.sv =====
// tb_top: self-checking testbench of the vertex normal averager
// depends on vna_pkg and the rtl of vertex_normal_averager
`timescale 1ns / 100ps

module tb_top;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  vna_pkg::in_word_t  in_word_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  vna_pkg::out_word_t out_word_o;

  vertex_normal_averager dut (.*);

  always #4 clk_i = ~clk_i;

  // predictor state: per-vertex sums and clip marks
  logic signed [31:0] acc_x [vna_pkg::StoreDepth];
  logic signed [31:0] acc_y [vna_pkg::StoreDepth];
  logic signed [31:0] acc_z [vna_pkg::StoreDepth];
  logic               acc_clip [vna_pkg::StoreDepth];
  vna_pkg::out_word_t pending_normals [$];

  int fails = 0;
  int words_sent = 0;
  int normals_seen = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_recv = 1'b0;

  function automatic logic signed [31:0] sat32(logic signed [31:0] a,
                                               logic signed [15:0] b, ref bit hit);
    logic signed [33:0] r;
    r = 34'(a) + 34'(b);
    if (r > 34'sh07FFFFFFF) begin
      hit = 1'b1;
      return 32'sh7FFFFFFF;
    end
    if (r < -34'sh080000000) begin
      hit = 1'b1;
      return 32'sh80000000;
    end
    return r[31:0];
  endfunction

  function automatic logic [63:0] root64(logic [63:0] n);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] mag(logic signed [31:0] v);
    return v < 0 ? 64'(-64'(v)) : 64'(v);
  endfunction

  function automatic logic signed [15:0] scale(logic signed [31:0] s, logic [63:0] len);
    logic [63:0] q;
    q = ((mag(s) << (vna_pkg::FracBits + 1)) + len) / (len << 1);
    if (q > (64'd1 << vna_pkg::FracBits)) q = 64'd1 << vna_pkg::FracBits;
    if (s < 0) q = -q;
    return q[15:0];
  endfunction

  task automatic add_face(logic [vna_pkg::IdxW-1:0] v, vna_pkg::in_word_t w);
    bit hit;
    hit = 1'b0;
    if (v >= vna_pkg::StoreDepth) return;
    acc_x[v] = sat32(acc_x[v], w.face_x, hit);
    acc_y[v] = sat32(acc_y[v], w.face_y, hit);
    acc_z[v] = sat32(acc_z[v], w.face_z, hit);
    if (hit) acc_clip[v] = 1'b1;
  endtask

  // update the model for one accepted word, queue a normal on reads
  task automatic predict_word(vna_pkg::in_word_t w);
    vna_pkg::out_word_t o;
    logic [63:0] sq, len;
    if (w.req_type == vna_pkg::REQ_ACCUM) begin
      add_face(w.vertex_a, w);
      add_face(w.vertex_b, w);
      add_face(w.vertex_c, w);
      return;
    end
    o = '0;
    o.zero_sum = 1'b1;
    if (w.vertex_a < vna_pkg::StoreDepth) begin
      sq = mag(acc_x[w.vertex_a]) * mag(acc_x[w.vertex_a])
         + mag(acc_y[w.vertex_a]) * mag(acc_y[w.vertex_a])
         + mag(acc_z[w.vertex_a]) * mag(acc_z[w.vertex_a]);
      o.clipped = acc_clip[w.vertex_a];
      if (sq != 0) begin
        len = root64(sq);
        o.unit_x = scale(acc_x[w.vertex_a], len);
        o.unit_y = scale(acc_y[w.vertex_a], len);
        o.unit_z = scale(acc_z[w.vertex_a], len);
        o.zero_sum = 1'b0;
      end
      acc_x[w.vertex_a] = 0;
      acc_y[w.vertex_a] = 0;
      acc_z[w.vertex_a] = 0;
      acc_clip[w.vertex_a] = 1'b0;
    end
    pending_normals.push_back(o);
  endtask

  // send one word, with random idle cycles before it; valid stays up after
  // the accept until the next word, an idle cycle or a drain replaces it
  task automatic send_word(vna_pkg::in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    predict_word(w);
    words_sent++;
  endtask

  // receiver stall pattern
  always @(posedge clk_i) begin
    out_stall_i <= hold_recv || ($urandom_range(99) < recv_stall_pct);
  end

  // result checker
  always @(posedge clk_i) begin
    vna_pkg::out_word_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      normals_seen++;
      if (pending_normals.size() == 0) begin
        $error("unexpected normal word %h", out_word_o);
        fails++;
      end else begin
        e = pending_normals.pop_front();
        if (out_word_o.unit_x !== e.unit_x) begin
          $error("unit_x exp %0d got %0d", e.unit_x, out_word_o.unit_x); fails++;
        end
        if (out_word_o.unit_y !== e.unit_y) begin
          $error("unit_y exp %0d got %0d", e.unit_y, out_word_o.unit_y); fails++;
        end
        if (out_word_o.unit_z !== e.unit_z) begin
          $error("unit_z exp %0d got %0d", e.unit_z, out_word_o.unit_z); fails++;
        end
        if (out_word_o.zero_sum !== e.zero_sum) begin
          $error("zero_sum exp %0d got %0d", e.zero_sum, out_word_o.zero_sum); fails++;
        end
        if (out_word_o.clipped !== e.clipped) begin
          $error("clipped exp %0d got %0d", e.clipped, out_word_o.clipped); fails++;
        end
      end
    end
  end

  function automatic vna_pkg::in_word_t tri_word(int a, int b, int c, int x, int y, int z);
    vna_pkg::in_word_t w;
    w.req_type = vna_pkg::REQ_ACCUM;
    w.vertex_a = 12'(a); w.vertex_b = 12'(b); w.vertex_c = 12'(c);
    w.face_x = 16'(x); w.face_y = 16'(y); w.face_z = 16'(z);
    return w;
  endfunction

  function automatic vna_pkg::in_word_t read_word(int v);
    vna_pkg::in_word_t w;
    w = vna_pkg::in_word_t'({$urandom, $urandom, $urandom});
    w.req_type = vna_pkg::REQ_READ;
    w.vertex_a = 12'(v);
    return w;
  endfunction

  function automatic logic signed [15:0] rnd_face();
    // mostly in range, sometimes any 16-bit pattern
    if ($urandom_range(9) == 0) return 16'($urandom);
    return 16'($urandom_range(32768) - 16384);
  endfunction

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_normals.size() != 0) @(posedge clk_i);
  endtask

  // extremes, repeated vertex, zero sum, out-of-range faces
  task automatic test_directed();
    send_word(read_word(0));
    send_word(tri_word(1, 2, 3, 16384, 0, 0));
    send_word(tri_word(1, 1, 4095, 0, -16384, 0));
    send_word(read_word(1));
    send_word(read_word(4095));
    send_word(read_word(2));
    send_word(read_word(3));
    send_word(tri_word(5, 5, 5, 100, -100, 0));
    send_word(tri_word(5, 6, 6, -300, 300, 0));
    send_word(read_word(5));
    send_word(tri_word(7, 7, 7, -32768, 32767, 1));
    send_word(tri_word(7, 8, 9, -1, 1, -16384));
    send_word(read_word(7));
    send_word(read_word(8));
    send_word(read_word(6));
    send_word(read_word(9));
    send_word(tri_word(10, 11, 12, 3, 4, 0));
    send_word(read_word(10));
    send_word(read_word(10));
    drain();
  endtask

  // large sums: reaching the 32-bit bound takes ~22k words on one vertex,
  // so this grows one vertex to large mixed-sign sums and reads it once
  task automatic test_saturation();
    for (int i = 0; i < 12; i++)
      send_word(tri_word(20, 20, 20, 32767, -32768, 16384));
    send_word(read_word(20));
    drain();
  endtask

  // random meshes on a small vertex window, reads mostly inside it
  task automatic test_random(int n);
    int base;
    base = $urandom_range(vna_pkg::StoreDepth - 32);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) begin
        send_word(read_word($urandom_range(9) == 0 ? $urandom_range(4095)
                                                   : base + $urandom_range(31)));
      end else if ($urandom_range(19) == 0) begin
        send_word(tri_word($urandom_range(4095), $urandom_range(4095),
                           $urandom_range(4095), rnd_face(), rnd_face(), rnd_face()));
      end else begin
        send_word(tri_word(base + $urandom_range(31), base + $urandom_range(31),
                           base + $urandom_range(31), rnd_face(), rnd_face(), rnd_face()));
      end
    end
  endtask

  // receiver holds off while reads keep coming, so the input stalls
  task automatic test_backpressure();
    fork
      begin
        hold_recv = 1'b1;
        repeat (600) @(posedge clk_i);
        hold_recv = 1'b0;
      end
      for (int i = 0; i < 6; i++) send_word(read_word(i + 100));
    join
    drain();
  endtask

  initial begin
    for (int i = 0; i < vna_pkg::StoreDepth; i++) begin
      acc_x[i] = 0; acc_y[i] = 0; acc_z[i] = 0; acc_clip[i] = 1'b0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_saturation();
    test_backpressure();
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random(200);
    drain();
    send_idle_pct = 70; recv_stall_pct = 0;  test_random(200);
    send_idle_pct = 0;  recv_stall_pct = 70; test_random(200);
    send_idle_pct = 10; recv_stall_pct = 10; test_random(200);
    drain();
    recv_stall_pct = 0;
    repeat (200) @(posedge clk_i);
    $display("sent %0d words, checked %0d normals over four idle/stall mixes",
             words_sent, normals_seen);
    if (fails == 0 && pending_normals.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
